/* rtl/brsm_pkg.sv */
// Shared types and constants for the byte-coded register/stack machine.
// No dependencies.
`default_nettype none
package brsm_pkg;

    // Instruction opcodes
    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_HALT = 8'h01;
    localparam logic [7:0] OP_LOAD = 8'h02;
    localparam logic [7:0] OP_STOR = 8'h03;
    localparam logic [7:0] OP_ADD  = 8'h04;
    localparam logic [7:0] OP_SUB  = 8'h05;
    localparam logic [7:0] OP_JMP  = 8'h06;
    localparam logic [7:0] OP_JZ   = 8'h07;
    localparam logic [7:0] OP_CALL = 8'h08;
    localparam logic [7:0] OP_RET  = 8'h09;
    localparam logic [7:0] OP_PUSH = 8'h0A;
    localparam logic [7:0] OP_POP  = 8'h0B;
    localparam logic [7:0] OP_OUT  = 8'h0C;
    localparam logic [7:0] OP_AND  = 8'h0D;
    localparam logic [7:0] OP_OR   = 8'h0E;
    localparam logic [7:0] OP_XOR  = 8'h0F;

    // Result status codes
    localparam logic [2:0] ST_DONE  = 3'd0;
    localparam logic [2:0] ST_HALT  = 3'd1;
    localparam logic [2:0] ST_REFUS = 3'd2;
    localparam logic [2:0] ST_BADOP = 3'd3;
    localparam logic [2:0] ST_LIMIT = 3'd4;

    // Item as queued between front and back
    typedef struct packed {
        logic        opcode;
        logic [15:0] load_address;
        logic [7:0]  load_data;
    } item_t;

    // Result item
    typedef struct packed {
        logic [2:0]  status;
        logic        out_valid;
        logic [31:0] out_value;
        logic [31:0] pc_after;
    } result_t;

endpackage
`default_nettype wire

/* rtl/brsm_front.sv */
// Front end: accepts items into a short queue and hands them to the executor.
// Depends on brsm_pkg.
`default_nettype none
module brsm_front
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    output logic                 full,
    input  brsm_pkg::item_t      in_item,
    output logic                 q_valid,
    output brsm_pkg::item_t      q_item,
    input  wire                  q_take
);
    import brsm_pkg::*;

    item_t      buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign full    = cnt_reg[1];
    assign q_valid = cnt_reg != 2'd0;
    assign q_item  = buf_reg[rd_ptr_reg];
    assign do_wr   = push && !full;
    assign do_rd   = q_take && q_valid;

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_wr) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_rd) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end
endmodule
`default_nettype wire

/* rtl/brsm_back.sv */
// Back end: executes queued items against memory, registers and stack.
// Depends on brsm_pkg. Result goes to a two-entry output queue.
`default_nettype none
module brsm_back
#(
    parameter int MEM_BYTES   = 65536,
    parameter int STACK_DEPTH = 256
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  q_valid,
    input  brsm_pkg::item_t      q_item,
    output logic                 q_take,
    input  wire  [63:0]          cycle_limit,
    output logic                 empty,
    input  wire                  pop,
    output brsm_pkg::result_t    res
);
    import brsm_pkg::*;

    localparam int AW  = $clog2(MEM_BYTES);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [32:0] MEM_TOP  = 33'(MEM_BYTES);
    localparam logic [SPW-1:0] SDEPTH = SPW'(STACK_DEPTH);

    // sequencer states
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_F0    = 4'd2;
    localparam logic [3:0] S_F1    = 4'd3;
    localparam logic [3:0] S_F2    = 4'd4;
    localparam logic [3:0] S_F3    = 4'd5;
    localparam logic [3:0] S_EXEC  = 4'd6;
    localparam logic [3:0] S_SPOP  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]      st_reg;
    logic [AW-1:0]   clr_reg;
    logic [31:0]     regs_reg [16];
    logic [31:0]     pc_reg;
    logic [SPW-1:0]  sp_reg;
    logic            halted_reg;
    logic [63:0]     ccount_reg;
    logic [7:0]      byte_reg [4];
    logic [2:0]      nfetch_reg;
    logic [2:0]      fidx_reg;

    // byte memory, single port, registered read
    logic [7:0]      mem [MEM_BYTES];
    logic [7:0]      mrd_reg;
    logic            m_we;
    logic [AW-1:0]   m_addr;
    logic [7:0]      m_wd;

    always_ff @(posedge clk)
    begin
        if (m_we) mem[m_addr] <= m_wd;
        mrd_reg <= mem[m_addr];
    end

    // stack memory
    logic [31:0]     stk [STACK_DEPTH];
    logic [31:0]     srd_reg;
    logic            s_we;
    logic [SW-1:0]   s_addr;
    logic [31:0]     s_wd;

    always_ff @(posedge clk)
    begin
        if (s_we) stk[s_addr] <= s_wd;
        srd_reg <= stk[s_addr];
    end

    // output queue, two entries
    result_t         oq_reg [2];
    logic            ow_reg, or_reg;
    logic [1:0]      ocnt_reg;
    logic            o_push;
    result_t         o_data;

    assign empty = ocnt_reg == 2'd0;
    assign res   = oq_reg[or_reg];

    always_ff @(posedge clk)
    begin
        if (o_push) oq_reg[ow_reg] <= o_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ow_reg   <= 1'b0;
            or_reg   <= 1'b0;
            ocnt_reg <= 2'd0;
        end
        else
        begin
            if (o_push) ow_reg <= ~ow_reg;
            if (pop && !empty) or_reg <= ~or_reg;
            ocnt_reg <= ocnt_reg + {1'b0, o_push} - {1'b0, pop && !empty};
        end
    end

    // decode helpers
    logic [7:0]  op;
    logic [3:0]  r1, r2, r3;
    logic [31:0] va, vb, vd, alu;
    logic [15:0] a16_b1, a16_b2;
    logic        stk_full, stk_empty;

    assign op       = byte_reg[0];
    assign r1       = byte_reg[1][3:0];
    assign r2       = byte_reg[2][3:0];
    assign r3       = byte_reg[3][3:0];
    assign vd       = regs_reg[r1];
    assign va       = regs_reg[r2];
    assign vb       = regs_reg[r3];
    assign a16_b1   = {byte_reg[2], byte_reg[1]};
    assign a16_b2   = {byte_reg[3], byte_reg[2]};
    assign stk_full  = sp_reg >= SDEPTH;
    assign stk_empty = sp_reg == '0;

    always_comb
    begin
        case (op)
            OP_ADD:  alu = va + vb;
            OP_SUB:  alu = va - vb;
            OP_AND:  alu = va & vb;
            OP_OR:   alu = va | vb;
            default: alu = va ^ vb;
        endcase
    end

    // bytes to fetch per opcode, including the opcode itself
    function automatic logic [2:0] op_len(input logic [7:0] o);
        logic [2:0] n;
        case (o)
            OP_LOAD, OP_JMP, OP_CALL:         n = 3'd3;
            OP_STOR, OP_JZ:                   n = 3'd4;
            OP_ADD, OP_SUB, OP_AND, OP_OR,
            OP_XOR:                           n = 3'd4;
            OP_PUSH, OP_POP, OP_OUT:          n = 3'd2;
            default:                          n = 3'd1;
        endcase
        return n;
    endfunction

    // only the executor pushes, so a free slot at start stays free until done
    logic room;
    assign room = ocnt_reg != 2'd2;

    logic [31:0] fetch_pc;
    assign fetch_pc = pc_reg + 32'(fidx_reg);

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_CLR;
            clr_reg    <= '0;
            pc_reg     <= '0;
            sp_reg     <= '0;
            halted_reg <= 1'b0;
            ccount_reg <= '0;
            nfetch_reg <= '0;
            fidx_reg   <= '0;
            for (int i = 0; i < 16; i++) regs_reg[i] <= '0;
        end
        else
        begin
            case (st_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg) st_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid && room)
                    begin
                        if (q_item.opcode &&
                            !(halted_reg || {1'b0, pc_reg} >= MEM_TOP) &&
                            !(ccount_reg >= cycle_limit))
                        begin
                            fidx_reg <= 3'd1;
                            st_reg   <= S_F0;
                        end
                    end
                end
                S_F0:
                begin
                    // opcode byte arrives
                    byte_reg[0] <= mrd_reg;
                    nfetch_reg  <= op_len(mrd_reg);
                    if (op_len(mrd_reg) == 3'd1)
                        st_reg <= S_EXEC;
                    else
                    begin
                        fidx_reg <= 3'd2;
                        st_reg   <= S_F1;
                    end
                end
                S_F1:
                begin
                    byte_reg[1] <= mrd_reg;
                    if (nfetch_reg == 3'd2) st_reg <= S_EXEC;
                    else
                    begin
                        fidx_reg <= 3'd3;
                        st_reg   <= S_F2;
                    end
                end
                S_F2:
                begin
                    byte_reg[2] <= mrd_reg;
                    if (nfetch_reg == 3'd3) st_reg <= S_EXEC;
                    else st_reg <= S_F3;
                end
                S_F3:
                begin
                    byte_reg[3] <= mrd_reg;
                    st_reg      <= S_EXEC;
                end
                S_EXEC:
                begin
                    ccount_reg <= ccount_reg + 64'd1;
                    st_reg     <= S_DONE;
                    case (op)
                        OP_HALT: halted_reg <= 1'b1;
                        OP_LOAD:
                        begin
                            regs_reg[r1] <= {24'd0, byte_reg[2]};
                            pc_reg <= pc_reg + 32'd3;
                        end
                        OP_STOR: pc_reg <= pc_reg + 32'd4;
                        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR:
                        begin
                            regs_reg[r1] <= alu;
                            pc_reg <= pc_reg + 32'd4;
                        end
                        OP_JMP: pc_reg <= {16'd0, a16_b1};
                        OP_JZ:
                            pc_reg <= (vd == 32'd0) ? {16'd0, a16_b2}
                                                    : pc_reg + 32'd4;
                        OP_CALL:
                        begin
                            if (!stk_full) sp_reg <= sp_reg + 1'b1;
                            pc_reg <= {16'd0, a16_b1};
                        end
                        OP_RET, OP_POP:
                        begin
                            if (!stk_empty)
                            begin
                                sp_reg <= sp_reg - 1'b1;
                                st_reg <= S_SPOP;
                            end
                            else
                                pc_reg <= pc_reg + ((op == OP_POP) ? 32'd2 : 32'd1);
                        end
                        OP_PUSH:
                        begin
                            if (!stk_full) sp_reg <= sp_reg + 1'b1;
                            pc_reg <= pc_reg + 32'd2;
                        end
                        OP_OUT: pc_reg <= pc_reg + 32'd2;
                        default: pc_reg <= pc_reg + 32'd1;
                    endcase
                    if (op == OP_HALT) pc_reg <= pc_reg + 32'd1;
                end
                S_SPOP:
                begin
                    if (op == OP_RET) pc_reg <= srd_reg;
                    else
                    begin
                        regs_reg[r1] <= srd_reg;
                        pc_reg <= pc_reg + 32'd2;
                    end
                    st_reg <= S_DONE;
                end
                S_DONE:
                begin
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // memory port and result generation
    always_comb
    begin
        m_we   = 1'b0;
        m_addr = fetch_pc[AW-1:0];
        m_wd   = vd[7:0];
        s_we   = 1'b0;
        s_addr = sp_reg[SW-1:0];
        s_wd   = vd;
        o_push = 1'b0;
        o_data = '0;
        q_take = 1'b0;
        case (st_reg)
            S_CLR:
            begin
                m_we   = 1'b1;
                m_addr = clr_reg;
                m_wd   = 8'd0;
            end
            S_IDLE:
            begin
                m_addr = pc_reg[AW-1:0];
                if (q_valid && room)
                begin
                    if (!q_item.opcode)
                    begin
                        q_take = 1'b1;
                        m_we   = 1'b1;
                        m_addr = q_item.load_address[AW-1:0];
                        m_wd   = q_item.load_data;
                        o_push = 1'b1;
                        o_data.status   = ST_DONE;
                        o_data.pc_after = pc_reg;
                    end
                    else if (halted_reg || {1'b0, pc_reg} >= MEM_TOP)
                    begin
                        q_take = 1'b1;
                        o_push = 1'b1;
                        o_data.status   = ST_REFUS;
                        o_data.pc_after = pc_reg;
                    end
                    else if (ccount_reg >= cycle_limit)
                    begin
                        q_take = 1'b1;
                        o_push = 1'b1;
                        o_data.status   = ST_LIMIT;
                        o_data.pc_after = pc_reg;
                    end
                end
            end
            S_EXEC:
            begin
                if (op == OP_STOR && {16'd0, a16_b1} < MEM_TOP[31:0])
                begin
                    m_we   = 1'b1;
                    m_addr = a16_b1[AW-1:0];
                end
                if (op == OP_PUSH && !stk_full) s_we = 1'b1;
                if (op == OP_CALL && !stk_full)
                begin
                    s_we = 1'b1;
                    s_wd = pc_reg + 32'd3;
                end
                m_wd = regs_reg[r3][7:0];
                s_addr = (op == OP_RET || op == OP_POP) ?
                         SW'(sp_reg - 1'b1) : sp_reg[SW-1:0];
            end
            S_DONE:
            begin
                q_take = 1'b1;
                o_push = 1'b1;
                o_data.pc_after = pc_reg;
                if (op == OP_HALT) o_data.status = ST_HALT;
                else if (op > OP_XOR) o_data.status = ST_BADOP;
                else o_data.status = ST_DONE;
                if (op == OP_OUT)
                begin
                    o_data.out_valid = 1'b1;
                    o_data.out_value = vd;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/bytecode_register_stack_machine.sv */
// Byte-coded register/stack machine. A write item, and a step refused for the
// halted state, a pc out of memory or the cycle limit, are handled in the
// idle state. An executed step runs serial operand fetches (one per cycle)
// from the single-port byte memory, then executes, with a stack read on
// RET/POP. After reset a clearing pass zeroes memory; items accepted during
// it wait in the two-entry input queue. Results wait in a two-entry output
// queue; the executor stalls while it is full.
// Depends on brsm_pkg, brsm_front, brsm_back.
`default_nettype none
module bytecode_register_stack_machine
#(
    parameter int MEM_BYTES   = 65536,
    parameter int STACK_DEPTH = 256
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         push,
    output logic        full,
    input  wire         opcode,
    input  wire  [15:0] load_address,
    input  wire  [7:0]  load_data,
    output logic        empty,
    input  wire         pop,
    output logic [2:0]  status,
    output logic        out_valid,
    output logic [31:0] out_value,
    output logic [31:0] pc_after,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [63:0] cfg_data
);
    import brsm_pkg::*;

    item_t   in_item, q_item;
    result_t res;
    logic    q_valid, q_take;
    logic [63:0] limit_reg;

    assign in_item = '{opcode: opcode, load_address: load_address,
                       load_data: load_data};
    assign cfg_ready = 1'b1;

    // cycle limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) limit_reg <= '1;
        else if (cfg_valid && cfg_ready) limit_reg <= cfg_data;
    end

    brsm_front u_front
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .in_item(in_item), .q_valid(q_valid), .q_item(q_item),
        .q_take(q_take)
    );

    brsm_back #(.MEM_BYTES(MEM_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_take(q_take), .cycle_limit(limit_reg),
        .empty(empty), .pop(pop), .res(res)
    );

    assign status    = res.status;
    assign out_valid = res.out_valid;
    assign out_value = res.out_value;
    assign pc_after  = res.pc_after;

    // checks
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid) else $error("queue taken while empty");
    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_valid) |-> out_value == 32'd0)
        else $error("out_value nonzero without out_valid");
    a_out_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_valid) |-> status == ST_DONE)
        else $error("out_valid with non-done status");
endmodule
`default_nettype wire
